@@ src/bfea_pkg.sv @@
package bfea_pkg;

   localparam int DefPoolUnits  = 4096;
   localparam int DefMaxExtents = 64;
   localparam int CntW   = 13;
   localparam int StartW = 12;
   localparam int StatW  = 3;

   localparam logic [StatW-1:0] ST_OK      = 3'd0;
   localparam logic [StatW-1:0] ST_BADCNT  = 3'd1;
   localparam logic [StatW-1:0] ST_NOFIT   = 3'd2;
   localparam logic [StatW-1:0] ST_BADREL  = 3'd3;
   localparam logic [StatW-1:0] ST_FULL    = 3'd4;

   localparam logic CMD_ACQUIRE = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   typedef struct packed {
      logic            command;
      logic [CntW-1:0] count;
      logic [StartW-1:0] start;
   } cmd_type;

   typedef struct packed {
      logic [StatW-1:0]  status;
      logic [StartW-1:0] alloc_start;
      logic [CntW-1:0]   free_units;
   } rsp_type;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_CHECK, S_SCAN, S_SCAN_WAIT, S_DECIDE, S_SHIFT_RD,
      S_SHIFT_WR, S_WRITE, S_DONE
   } state_type;

endpackage

@@ src/bfea_front.sv @@
module bfea_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [31:0]       req_tdata,
   input  logic              req_tuser,
   output logic              q_valid,
   input  logic              q_ready,
   output bfea_pkg::cmd_type q_cmd
);
   import bfea_pkg::*;

   cmd_type     buf_ff [2];
   logic [1:0]  cnt_ff, cnt_in;
   logic        wp_ff, rp_ff;
   cmd_type     beat;
   logic        push, pop;

   assign beat.command = req_tuser;
   assign beat.count   = req_tdata[CntW-1:0];
   assign beat.start   = req_tdata[CntW+StartW-1:CntW];

   assign req_tready = (cnt_ff != 2'd2);
   assign push    = req_tvalid && req_tready;
   assign q_valid = (cnt_ff != 2'd0);
   assign pop     = q_valid && q_ready;
   assign q_cmd   = buf_ff[rp_ff];

   always_comb begin
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
      end
      if (push) buf_ff[wp_ff] <= beat;
   end
endmodule

@@ src/bfea_back.sv @@
module bfea_back #(
   parameter int PoolUnits  = bfea_pkg::DefPoolUnits,
   parameter int MaxExtents = bfea_pkg::DefMaxExtents
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  logic [bfea_pkg::CntW-1:0] csr_wr_data,
   input  logic                    q_valid,
   output logic                    q_ready,
   input  bfea_pkg::cmd_type       q_cmd,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output bfea_pkg::rsp_type       rsp
);
   import bfea_pkg::*;

   localparam int IdxW = $clog2(MaxExtents);
   localparam int UsedW = $clog2(MaxExtents + 1);
   localparam int CapRaw = (PoolUnits > 8191) ? 8191 : PoolUnits;
   localparam logic [CntW-1:0] PoolCap = CapRaw[CntW-1:0];
   localparam logic [UsedW-1:0] MaxUsed = MaxExtents[UsedW-1:0];

   logic [StartW-1:0] mem_first [MaxExtents];
   logic [CntW-1:0]   mem_len   [MaxExtents];
   logic [StartW-1:0] rd_first_ff;
   logic [CntW-1:0]   rd_len_ff;

   state_type state_ff, state_in;
   logic [UsedW-1:0] used_ff, used_in;
   logic [CntW-1:0]  free_ff, free_in, pool_ff;
   logic [UsedW-1:0] idx_ff, idx_in;
   cmd_type          cmd_ff, cmd_in;
   logic             found_ff, found_in, exact_ff, exact_in;
   logic [IdxW-1:0]  best_ff, best_in;
   logic [CntW-1:0]  blen_ff, blen_in;
   logic [StartW-1:0] bfirst_ff, bfirst_in;
   logic             lval_ff, lval_in;
   logic [CntW:0]    lend_ff, lend_in;
   logic [StartW-1:0] lfirst_ff, lfirst_in;
   logic [CntW-1:0]  llen_ff, llen_in;
   logic             rval_ff, rval_in;
   logic [StartW-1:0] rfirst_ff, rfirst_in;
   logic [CntW-1:0]  rlen_ff, rlen_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rv_ff, rv_in;
   logic             shift_up_ff, shift_up_in;
   logic [UsedW-1:0] stop_ff, stop_in;

   logic             rd_en, wr_en;
   logic [IdxW-1:0]  rd_addr, wr_addr;
   logic [StartW-1:0] wr_first;
   logic [CntW-1:0]  wr_len;
   logic [CntW:0]    rend, end_w;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_first[wr_addr] <= wr_first;
         mem_len[wr_addr]   <= wr_len;
      end
      if (rd_en) begin
         rd_first_ff <= mem_first[rd_addr];
         rd_len_ff   <= mem_len[rd_addr];
      end
   end

   assign rsp        = rsp_ff;
   assign rsp_tvalid = rv_ff;
   assign rend  = {2'b00, rd_first_ff} + {1'b0, rd_len_ff};
   assign end_w = {2'b00, cmd_ff.start} + {1'b0, cmd_ff.count};

   always_comb begin
      logic [CntW-1:0] cnt;
      state_in = state_ff; used_in = used_ff; free_in = free_ff; idx_in = idx_ff;
      cmd_in = cmd_ff; found_in = found_ff; exact_in = exact_ff; best_in = best_ff;
      blen_in = blen_ff; bfirst_in = bfirst_ff; lval_in = lval_ff; lend_in = lend_ff;
      lfirst_in = lfirst_ff; llen_in = llen_ff; rval_in = rval_ff;
      rfirst_in = rfirst_ff; rlen_in = rlen_ff; rsp_in = rsp_ff; rv_in = rv_ff;
      shift_up_in = shift_up_ff; stop_in = stop_ff;
      rd_en = 1'b0; rd_addr = idx_ff[IdxW-1:0];
      wr_en = 1'b0; wr_addr = idx_ff[IdxW-1:0]; wr_first = '0; wr_len = '0;
      q_ready = 1'b0;
      cnt = cmd_ff.count;
      if (rv_ff && rsp_tready) rv_in = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            wr_en = 1'b1; wr_addr = '0; wr_first = '0; wr_len = pool_ff;
            used_in = {{(UsedW-1){1'b0}}, 1'b1}; free_in = pool_ff;
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (!rv_ff) begin
               q_ready = 1'b1;
               if (q_valid) begin
                  cmd_in = q_cmd; idx_in = '0; found_in = 1'b0; exact_in = 1'b0;
                  lval_in = 1'b0; rval_in = 1'b0; state_in = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            if (cmd_ff.command == CMD_ACQUIRE) begin
               if (cnt == '0 || cnt > free_ff) begin
                  rsp_in = '{ST_BADCNT, '0, free_ff}; rv_in = 1'b1; state_in = S_IDLE;
               end else begin
                  state_in = S_SCAN;
               end
            end else if (cnt == '0 || end_w > {1'b0, pool_ff}) begin
               rsp_in = '{ST_BADREL, '0, free_ff}; rv_in = 1'b1; state_in = S_IDLE;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (idx_ff >= used_ff) begin
               state_in = S_DECIDE;
            end else begin
               rd_en = 1'b1; state_in = S_SCAN_WAIT;
            end
         end
         S_SCAN_WAIT: begin
            idx_in = idx_ff + 1'b1;
            state_in = S_SCAN;
            if (cmd_ff.command == CMD_ACQUIRE) begin
               if (rd_len_ff == cnt) begin
                  found_in = 1'b1; exact_in = 1'b1; best_in = idx_ff[IdxW-1:0];
                  blen_in = rd_len_ff; bfirst_in = rd_first_ff; state_in = S_DECIDE;
               end else if (rd_len_ff > cnt && (!found_ff || rd_len_ff < blen_ff)) begin
                  found_in = 1'b1; best_in = idx_ff[IdxW-1:0];
                  blen_in = rd_len_ff; bfirst_in = rd_first_ff;
               end
            end else if (rd_first_ff < cmd_ff.start) begin
               lval_in = 1'b1; lend_in = rend; lfirst_in = rd_first_ff; llen_in = rd_len_ff;
            end else begin
               rval_in = 1'b1; rfirst_in = rd_first_ff; rlen_in = rd_len_ff;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (cmd_ff.command == CMD_ACQUIRE) begin
               if (!found_ff) begin
                  rsp_in = '{ST_NOFIT, '0, free_ff}; rv_in = 1'b1; state_in = S_IDLE;
               end else begin
                  free_in = free_ff - cnt;
                  rsp_in = '{ST_OK, bfirst_ff, free_ff - cnt};
                  if (exact_ff) begin
                     shift_up_in = 1'b0; idx_in = {1'b0, best_ff} + 1'b1;
                     stop_in = used_ff; used_in = used_ff - 1'b1; state_in = S_SHIFT_RD;
                  end else begin
                     wr_en = 1'b1; wr_addr = best_ff;
                     wr_first = bfirst_ff + cnt[StartW-1:0]; wr_len = blen_ff - cnt;
                     rv_in = 1'b1; state_in = S_IDLE;
                  end
               end
            end else begin
               // p is idx_ff - 1 when a right neighbor stopped the scan, else idx_ff.
               if ((lval_ff && lend_ff > {2'b00, cmd_ff.start}) ||
                   (rval_ff && {2'b00, rfirst_ff} < end_w)) begin
                  rsp_in = '{ST_BADREL, '0, free_ff}; rv_in = 1'b1; state_in = S_IDLE;
               end else if (lval_ff && lend_ff == {2'b00, cmd_ff.start}) begin
                  free_in = free_ff + cnt;
                  rsp_in = '{ST_OK, '0, free_ff + cnt};
                  wr_en = 1'b1;
                  wr_addr = rval_ff ? idx_ff[IdxW-1:0] - IdxW'(2) :
                                      idx_ff[IdxW-1:0] - IdxW'(1);
                  wr_first = lfirst_ff;
                  if (rval_ff && {2'b00, rfirst_ff} == end_w) begin
                     wr_len = llen_ff + cnt + rlen_ff;
                     shift_up_in = 1'b0; stop_in = used_ff; used_in = used_ff - 1'b1;
                     state_in = S_SHIFT_RD;
                  end else begin
                     wr_len = llen_ff + cnt;
                     rv_in = 1'b1; state_in = S_IDLE;
                  end
               end else if (rval_ff && {2'b00, rfirst_ff} == end_w) begin
                  free_in = free_ff + cnt;
                  rsp_in = '{ST_OK, '0, free_ff + cnt};
                  wr_en = 1'b1; wr_addr = idx_ff[IdxW-1:0] - IdxW'(1);
                  wr_first = cmd_ff.start; wr_len = rlen_ff + cnt;
                  rv_in = 1'b1; state_in = S_IDLE;
               end else if (used_ff >= MaxUsed) begin
                  rsp_in = '{ST_FULL, '0, free_ff}; rv_in = 1'b1; state_in = S_IDLE;
               end else begin
                  free_in = free_ff + cnt;
                  rsp_in = '{ST_OK, '0, free_ff + cnt};
                  shift_up_in = 1'b1;
                  stop_in = rval_ff ? idx_ff - 1'b1 : idx_ff;
                  idx_in = used_ff; used_in = used_ff + 1'b1;
                  state_in = (idx_in == stop_in) ? S_WRITE : S_SHIFT_RD;
                  if (rval_ff) state_in = (used_ff == idx_ff - 1'b1) ? S_WRITE : S_SHIFT_RD;
               end
            end
         end
         S_SHIFT_RD: begin
            if (!shift_up_ff && idx_ff >= stop_ff) begin
               rv_in = 1'b1; state_in = S_IDLE;
            end else begin
               rd_en = 1'b1;
               rd_addr = shift_up_ff ? idx_ff[IdxW-1:0] - IdxW'(1) : idx_ff[IdxW-1:0];
               state_in = S_SHIFT_WR;
            end
         end
         S_SHIFT_WR: begin
            wr_en = 1'b1; wr_first = rd_first_ff; wr_len = rd_len_ff;
            if (shift_up_ff) begin
               wr_addr = idx_ff[IdxW-1:0];
               idx_in = idx_ff - 1'b1;
               state_in = (idx_in == stop_ff) ? S_WRITE : S_SHIFT_RD;
            end else begin
               wr_addr = idx_ff[IdxW-1:0] - IdxW'(1);
               idx_in = idx_ff + 1'b1;
               state_in = S_SHIFT_RD;
            end
         end
         S_WRITE: begin
            wr_en = 1'b1; wr_addr = stop_ff[IdxW-1:0];
            wr_first = cmd_ff.start; wr_len = cnt;
            rv_in = 1'b1; state_in = S_IDLE;
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      if (csr_wr_en) begin
         state_in = S_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         pool_ff  <= PoolCap;
         used_ff  <= '0;
         free_ff  <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
         free_ff  <= free_in;
         rv_ff    <= rv_in;
         if (csr_wr_en) pool_ff <= (csr_wr_data == '0) ? {{(CntW-1){1'b0}}, 1'b1} :
            ((csr_wr_data > PoolCap) ? PoolCap : csr_wr_data);
      end
      idx_ff <= idx_in; cmd_ff <= cmd_in; found_ff <= found_in; exact_ff <= exact_in;
      best_ff <= best_in; blen_ff <= blen_in; bfirst_ff <= bfirst_in;
      lval_ff <= lval_in; lend_ff <= lend_in; lfirst_ff <= lfirst_in; llen_ff <= llen_in;
      rval_ff <= rval_in; rfirst_ff <= rfirst_in; rlen_ff <= rlen_in;
      rsp_ff <= rsp_in; shift_up_ff <= shift_up_in; stop_ff <= stop_in;
   end
endmodule

@@ src/best_fit_extent_allocator.sv @@
// Best-fit allocator over a pool of units kept as an address-ordered table of free
// extents in a single-port memory. Each beat carries an acquire or a release and
// yields one response beat with a status, the granted start and the free total.
// Scanning reads each table entry in turn (S_SCAN, S_SCAN_WAIT) and a shift moves
// each entry by a read and a write (S_SHIFT_RD, S_SHIFT_WR); the back end starts
// the next beat only once the response beat is taken, and a pool size write
// restarts the table through S_CLEAR. A two-beat queue decouples the request side.
module best_fit_extent_allocator #(
   parameter int PoolUnits  = bfea_pkg::DefPoolUnits,
   parameter int MaxExtents = bfea_pkg::DefMaxExtents
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [12:0] csr_wr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // req_count, req_start
   input  logic        req_tuser,   // command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // status, alloc_start, free_units
);
   import bfea_pkg::*;

   logic    q_valid, q_ready;
   cmd_type q_cmd;
   rsp_type rsp;

   bfea_front u_front (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .q_valid, .q_ready, .q_cmd
   );

   bfea_back #(.PoolUnits(PoolUnits), .MaxExtents(MaxExtents)) u_back (
      .clock, .reset, .csr_wr_en, .csr_wr_data, .q_valid, .q_ready, .q_cmd,
      .rsp_tvalid, .rsp_tready, .rsp
   );

   assign rsp_tdata = {4'd0, rsp.free_units, rsp.alloc_start, rsp.status};
endmodule

@@ src/bfea_checker.sv @@
module bfea_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);
   import bfea_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response dropped while stalled");
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[2:0] <= ST_FULL)
      else $error("bad status");
   a_start: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] != ST_OK |-> rsp_tdata[14:3] == 12'd0)
      else $error("start on failure");
   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[31:28] == 4'd0)
      else $error("padding set");
endmodule

bind best_fit_extent_allocator bfea_checker u_chk (
   .clock, .reset, .rsp_tvalid, .rsp_tready, .rsp_tdata
);

@@ sim/tb.sv @@
module tb;
   import bfea_pkg::*;

   localparam int ClockLimit = 3000000;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [12:0] csr_wr_data;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;

   typedef struct {
      logic [StatW-1:0]  status;
      logic [StartW-1:0] alloc_start;
      logic [CntW-1:0]   free_units;
   } outcome_type;

   typedef struct {
      int first;
      int len;
   } run_type;

   outcome_type pending_outcomes[$];
   run_type     held_runs[$];

   int free_first[DefMaxExtents];
   int free_len[DefMaxExtents];
   int ext_count;
   int free_sum;
   int pool_units;

   int errors = 0;
   int cycles = 0;
   int beats_sent;
   int beats_checked = 0;
   int send_idle_pct;
   int recv_stall_pct;
   int full_rejects;

   best_fit_extent_allocator DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void restart_pool(int units);
      pool_units = units;
      free_first[0] = 0;
      free_len[0] = units;
      ext_count = 1;
      free_sum = units;
      held_runs.delete();
   endfunction

   function automatic void drop_extent(int p);
      for (int i = p; i + 1 < ext_count; i++) begin
         free_first[i] = free_first[i + 1];
         free_len[i] = free_len[i + 1];
      end
      ext_count--;
   endfunction

   function automatic logic [StatW-1:0] take_run(int count, output int granted);
      int best;
      bit found;
      best = 0;
      found = 0;
      granted = 0;
      if (count == 0 || count > free_sum) return ST_BADCNT;
      for (int i = 0; i < ext_count; i++) begin
         if (free_len[i] == count) begin
            best = i;
            found = 1;
            break;
         end
         if (free_len[i] > count && (!found || free_len[i] < free_len[best])) begin
            best = i;
            found = 1;
         end
      end
      if (!found) return ST_NOFIT;
      granted = free_first[best];
      if (free_len[best] == count) begin
         drop_extent(best);
      end else begin
         free_first[best] += count;
         free_len[best] -= count;
      end
      free_sum -= count;
      return ST_OK;
   endfunction

   function automatic logic [StatW-1:0] give_back(int first, int count);
      int last;
      int p;
      bit left;
      bit right;
      last = first + count;
      p = 0;
      if (count == 0 || last > pool_units) return ST_BADREL;
      while (p < ext_count && free_first[p] < first) p++;
      if (p > 0 && free_first[p - 1] + free_len[p - 1] > first) return ST_BADREL;
      if (p < ext_count && free_first[p] < last) return ST_BADREL;
      left = (p > 0) && (free_first[p - 1] + free_len[p - 1] == first);
      right = (p < ext_count) && (free_first[p] == last);
      if (left && right) begin
         free_len[p - 1] += count + free_len[p];
         drop_extent(p);
      end else if (left) begin
         free_len[p - 1] += count;
      end else if (right) begin
         free_first[p] = first;
         free_len[p] += count;
      end else begin
         if (ext_count >= DefMaxExtents) return ST_FULL;
         for (int i = ext_count; i > p; i--) begin
            free_first[i] = free_first[i - 1];
            free_len[i] = free_len[i - 1];
         end
         free_first[p] = first;
         free_len[p] = count;
         ext_count++;
      end
      free_sum += count;
      return ST_OK;
   endfunction

   function automatic outcome_type allocator_outcome(logic command, int count, int first);
      outcome_type o;
      int granted;
      granted = 0;
      if (command == CMD_ACQUIRE) begin
         o.status = take_run(count, granted);
         if (o.status == ST_OK) held_runs.push_back('{granted, count});
      end else begin
         o.status = give_back(first, count);
      end
      if (o.status == ST_FULL) full_rejects++;
      o.alloc_start = (o.status == ST_OK && command == CMD_ACQUIRE) ? granted[11:0] : '0;
      o.free_units = free_sum[12:0];
      return o;
   endfunction

   task automatic send_beat(logic command, int count, int first);
      int gap;
      gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {7'd0, first[11:0], count[12:0]};
      req_tuser <= command;
      do @(posedge clock); while (!req_tready);
      pending_outcomes.push_back(allocator_outcome(command, count, first));
      beats_sent++;
   endtask

   task automatic acquire(int count);
      send_beat(CMD_ACQUIRE, count, $urandom_range(4095));
   endtask

   task automatic release_run(int first, int count);
      send_beat(CMD_RELEASE, count, first);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_pool_size(logic [12:0] value);
      int units;
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      units = value;
      if (units == 0) units = 1;
      if (units > DefPoolUnits) units = DefPoolUnits;
      restart_pool(units);
   endtask

   task automatic test_basic_edges();
      acquire(0);
      acquire(4097);
      acquire(4096);
      acquire(1);
      release_run(4095, 1);
      release_run(4095, 2);
      release_run(0, 0);
      release_run(0, 4096);
      release_run(4095, 1);
      release_run(0, 4095);
      acquire(100);
      acquire(200);
      acquire(300);
      release_run(100, 200);
      release_run(100, 200);
      release_run(150, 10);
      acquire(200);
      release_run(0, 100);
      release_run(100, 200);
      release_run(300, 300);
      acquire(8191);
   endtask

   task automatic test_best_fit();
      write_pool_size(13'd40);
      acquire(40);
      release_run(0, 5);
      release_run(10, 3);
      release_run(20, 8);
      release_run(30, 3);
      acquire(3);
      acquire(4);
      acquire(9);
      acquire(6);
      release_run(5, 5);
   endtask

   task automatic test_pool_extremes();
      write_pool_size(13'd0);
      acquire(2);
      acquire(1);
      release_run(0, 1);
      write_pool_size(13'd8191);
      acquire(4096);
      release_run(2048, 2048);
      write_pool_size(13'd4096);
   endtask

   task automatic test_table_full();
      write_pool_size(13'd200);
      acquire(200);
      for (int i = 0; i < DefMaxExtents; i++) release_run(2 * i, 1);
      release_run(2 * DefMaxExtents + 1, 3);
      release_run(2 * DefMaxExtents, 1);
      release_run(1, 1);
      acquire(1);
   endtask

   task automatic random_traffic(int n);
      int pick;
      int idx;
      int cnt;
      for (int k = 0; k < n; k++) begin
         pick = $urandom_range(99);
         if (pick < 50 || held_runs.size() == 0) begin
            case ($urandom_range(9))
               0: cnt = $urandom_range(0, 8191);
               1: cnt = $urandom_range(0, pool_units + 1);
               default: cnt = $urandom_range(1, (pool_units < 64) ? pool_units : 64);
            endcase
            acquire(cnt);
         end else if (pick < 88) begin
            idx = $urandom_range(held_runs.size() - 1);
            if ($urandom_range(3) == 0 && held_runs[idx].len > 1) begin
               cnt = $urandom_range(1, held_runs[idx].len - 1);
               release_run(held_runs[idx].first, cnt);
               held_runs[idx].first += cnt;
               held_runs[idx].len -= cnt;
            end else begin
               release_run(held_runs[idx].first, held_runs[idx].len);
               held_runs.delete(idx);
            end
         end else begin
            release_run($urandom_range(4095), $urandom_range(0, 8191) >> $urandom_range(12));
         end
      end
   endtask

   task automatic test_random_phases();
      int sizes[4];
      sizes = '{4096, 300, $urandom_range(1, 8191), $urandom_range(2, 100)};
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
            default: begin send_idle_pct = 31; recv_stall_pct = 31; end
         endcase
         write_pool_size(sizes[ph][12:0]);
         random_traffic(300);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      outcome_type want;
      cycles++;
      if (cycles > ClockLimit) begin
         $display("Timeout after %0d cycles", cycles);
         $display("FAIL best_fit_extent_allocator");
         $finish;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         beats_checked++;
         if (pending_outcomes.size() == 0) begin
            errors++;
            $display("%0t: response beat expected none actual %h", $realtime, rsp_tdata);
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_tdata[2:0] !== want.status) begin
               errors++;
               $display("%0t: status expected %0d actual %0d", $realtime, want.status,
                        rsp_tdata[2:0]);
            end
            if (rsp_tdata[14:3] !== want.alloc_start) begin
               errors++;
               $display("%0t: alloc_start expected %0d actual %0d", $realtime,
                        want.alloc_start, rsp_tdata[14:3]);
            end
            if (rsp_tdata[27:15] !== want.free_units) begin
               errors++;
               $display("%0t: free_units expected %0d actual %0d", $realtime,
                        want.free_units, rsp_tdata[27:15]);
            end
         end
      end
   end

   initial begin
      beats_sent = 0;
      full_rejects = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      restart_pool(DefPoolUnits);
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_basic_edges();
      test_best_fit();
      test_pool_extremes();
      test_table_full();
      send_idle_pct = 31;
      recv_stall_pct = 31;
      test_best_fit();
      test_random_phases();
      drain();
      $display("Sent %0d request beats and checked %0d response beats across four pool",
               beats_sent, beats_checked);
      $display("sizes and four idling mixes; %0d releases hit a full table.", full_rejects);
      if (errors == 0 && pending_outcomes.size() == 0) begin
         $display("PASS best_fit_extent_allocator");
      end else begin
         $display("FAIL best_fit_extent_allocator");
      end
      $finish;
   end
endmodule
